[hdl/sv39ptw_pkg.sv]
// ----------------------------------------------------------------------------
// sv39ptw_pkg
// Shared types and constants for the Sv39 page table walker: result kinds,
// fault codes, register indexes and PTE field layout.
// ----------------------------------------------------------------------------
package sv39ptw_pkg;

  // Walk depth of Sv39
  localparam int unsigned LEVELS    = 3;
  localparam logic [1:0]  TOP_LEVEL = 2'(LEVELS - 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 44;
  localparam logic [CFG_IDX_W-1:0] REG_PAGING_ON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_PPN  = 2'd1;

  // Field widths
  localparam int unsigned VA_W   = 39;
  localparam int unsigned PPN_W  = 44;
  localparam int unsigned PPN2_W = 26;
  localparam int unsigned VPN_W  = 9;
  localparam int unsigned OFF_W  = 12;

  // Result kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_FAULT = 2'd2;

  // Access kinds
  localparam logic [1:0] ACC_FETCH = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;

  // Fault codes
  localparam logic [1:0] FC_NONE  = 2'd0;
  localparam logic [1:0] FC_INSTR = 2'd1;
  localparam logic [1:0] FC_LOAD  = 2'd2;
  localparam logic [1:0] FC_STORE = 2'd3;

  // Input beat modes
  localparam logic MODE_REQ = 1'b0;
  localparam logic MODE_PTE = 1'b1;

  // Fault code for an access kind; kind three counts as store/AMO
  function automatic logic [1:0] fault_for(input logic [1:0] acc);
    logic [1:0] code;
    case (acc)
      ACC_FETCH: code = FC_INSTR;
      ACC_LOAD:  code = FC_LOAD;
      default:   code = FC_STORE;
    endcase
    return code;
  endfunction

  // VPN slice of a virtual address at a given level
  function automatic logic [VPN_W-1:0] vpn_at(input logic [VA_W-1:0] va,
                                              input logic [1:0] lvl);
    logic [VPN_W-1:0] vpn;
    case (lvl)
      2'd0:    vpn = va[20:12];
      2'd1:    vpn = va[29:21];
      2'd2:    vpn = va[38:30];
      default: vpn = '0;
    endcase
    return vpn;
  endfunction

endpackage

[hdl/sv39_page_table_walker.sv]
// ----------------------------------------------------------------------------
// sv39_page_table_walker
// Three-level Sv39 page table walker. Takes translate requests and returned
// PTEs on one input channel, emits PTE read requests, translations and page
// faults on the result channel.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | input     | in_valid/in_ready  | mode, vaddr, access_kind, pte_word
//  out     | output    | out_valid/out_ready| result_kind, address, fault_code
//  cfg     | input     | cfg_we (no wait)   | cfg_index, cfg_wdata
//
//  One beat per cycle while in_ready is high: each input beat is decoded
//  against the walk state in one pass and its result lands in the output
//  register on the next edge.
//  in_ready is high while the output register is empty or being drained.
//  Beats out of turn (request while walking, PTE while idle) make no result.
//  Synchronous active-low reset idles the walker; result payload is not reset.
// ----------------------------------------------------------------------------
module sv39_page_table_walker
  import sv39ptw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [63:0]           in_vaddr,
  input  logic [1:0]            in_access_kind,
  input  logic [63:0]           in_pte_word,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_result_kind,
  output logic [63:0]           out_address,
  output logic [1:0]            out_fault_code
);

  // Registers
  logic             paging_on_r;
  logic [PPN_W-1:0] root_ppn_r;
  logic             walk_busy_r,   walk_busy_nxt;
  logic [1:0]       walk_level_r,  walk_level_nxt;
  logic [VA_W-1:0]  saved_va_r,    saved_va_nxt;
  logic [1:0]       saved_acc_r,   saved_acc_nxt;
  logic             out_valid_r,   out_valid_nxt;
  logic [1:0]       out_kind_r,    out_kind_nxt;
  logic [63:0]      out_addr_r,    out_addr_nxt;
  logic [1:0]       out_code_r,    out_code_nxt;

  logic             in_fire;
  logic             res_valid;
  logic [1:0]       res_kind;
  logic [63:0]      res_addr;
  logic [1:0]       res_code;

  // PTE fields
  logic              pte_v, pte_r, pte_w, pte_x;
  logic [PPN_W-1:0]  pte_ppn;
  logic [VPN_W-1:0]  pte_ppn1;
  logic [PPN2_W-1:0] pte_ppn2;
  logic [1:0]        next_level;
  logic [OFF_W-1:0]  va_off;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign pte_v    = in_pte_word[0];
  assign pte_r    = in_pte_word[1];
  assign pte_w    = in_pte_word[2];
  assign pte_x    = in_pte_word[3];
  assign pte_ppn  = in_pte_word[53:10];
  assign pte_ppn1 = in_pte_word[27:19];
  assign pte_ppn2 = in_pte_word[53:28];
  assign va_off   = saved_va_r[OFF_W-1:0];
  assign next_level = walk_level_r - 2'd1;

  // Decode one beat against the walk state
  always_comb begin
    walk_busy_nxt  = walk_busy_r;
    walk_level_nxt = walk_level_r;
    saved_va_nxt   = saved_va_r;
    saved_acc_nxt  = saved_acc_r;
    res_valid      = 1'b0;
    res_kind       = KIND_READ;
    res_addr       = '0;
    res_code       = FC_NONE;
    if (in_fire) begin
      if (in_mode == MODE_REQ) begin
        if (!walk_busy_r) begin
          res_valid = 1'b1;
          if (!paging_on_r) begin
            res_kind = KIND_DONE;
            res_addr = in_vaddr;
          end else begin
            saved_va_nxt   = in_vaddr[VA_W-1:0];
            saved_acc_nxt  = in_access_kind;
            walk_level_nxt = TOP_LEVEL;
            walk_busy_nxt  = 1'b1;
            res_kind       = KIND_READ;
            res_addr       = {8'd0, root_ppn_r, in_vaddr[38:30], 3'd0};
          end
        end
      end else if (walk_busy_r) begin
        res_valid = 1'b1;
        if (!pte_v || (!pte_r && pte_w)) begin
          // invalid or reserved encoding
          walk_busy_nxt = 1'b0;
          res_kind      = KIND_FAULT;
          res_code      = fault_for(saved_acc_r);
        end else if (pte_r || pte_x) begin
          // leaf: compose page by level
          walk_busy_nxt = 1'b0;
          res_kind      = KIND_DONE;
          case (walk_level_r)
            2'd0:    res_addr = {8'd0, pte_ppn, va_off};
            2'd1:    res_addr = {8'd0, pte_ppn2, pte_ppn1, vpn_at(saved_va_r, 2'd0), va_off};
            default: res_addr = {8'd0, pte_ppn2, vpn_at(saved_va_r, 2'd1),
                                 vpn_at(saved_va_r, 2'd0), va_off};
          endcase
        end else if (walk_level_r == 2'd0) begin
          // pointer at the last level
          walk_busy_nxt = 1'b0;
          res_kind      = KIND_FAULT;
          res_code      = fault_for(saved_acc_r);
        end else begin
          walk_level_nxt = next_level;
          res_kind       = KIND_READ;
          res_addr       = {8'd0, pte_ppn, vpn_at(saved_va_r, next_level), 3'd0};
        end
      end
    end
  end

  // Output register: load on a result, drain on a taken beat
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_addr_nxt  = out_addr_r;
    out_code_nxt  = out_code_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = res_kind;
      out_addr_nxt  = res_addr;
      out_code_nxt  = res_code;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paging_on_r  <= 1'b0;
      root_ppn_r   <= '0;
      walk_busy_r  <= 1'b0;
      walk_level_r <= TOP_LEVEL;
      saved_va_r   <= '0;
      saved_acc_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PAGING_ON: paging_on_r <= cfg_wdata[0];
          REG_ROOT_PPN:  root_ppn_r  <= cfg_wdata[PPN_W-1:0];
          default:       ;
        endcase
      end
      walk_busy_r  <= walk_busy_nxt;
      walk_level_r <= walk_level_nxt;
      saved_va_r   <= saved_va_nxt;
      saved_acc_r  <= saved_acc_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_addr_r <= out_addr_nxt;
    out_code_r <= out_code_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_address     = out_addr_r;
  assign out_fault_code  = out_code_r;

`ifndef SYNTHESIS
  // Walk level stays within the three Sv39 levels
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    walk_level_r != 2'd3)
    else $error("walk level out of range");

  // A pending read request always belongs to an active walk
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_READ) |-> walk_busy_r)
    else $error("read request pending while walker idle");

  // Faults carry a code and no address; other results carry no code
  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_kind_r == KIND_FAULT) ?
                     (out_code_r != FC_NONE && out_addr_r == 64'd0) :
                     (out_code_r == FC_NONE)))
    else $error("fault code and result kind disagree");

  // A request taken while idle with paging on starts at the top level
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_mode == MODE_REQ && !walk_busy_r && paging_on_r) |=>
      (walk_busy_r && walk_level_r == TOP_LEVEL && out_valid_r &&
       out_kind_r == KIND_READ))
    else $error("walk did not start at the top level");
`endif

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Sv39 page table walker. A scoreboard tracks the
// walk state and registers, predicts each result from the input beats that the
// block accepts, and compares result beats in order. Stimulus is a directed
// set of corner cases and then random walks with noise. Both channels stall
// at random.
// ----------------------------------------------------------------------------
import sv39ptw_pkg::*;

typedef struct packed {
  logic [1:0]  kind;
  logic [63:0] addr;
  logic [1:0]  code;
} walk_result_t;

// Walk predictor plus queue of expected result beats
class walk_scoreboard;
  logic         paging;
  logic [43:0]  root;
  logic         busy;
  logic [1:0]   level;
  logic [38:0]  va;
  logic [1:0]   acc;
  walk_result_t pending_results[$];
  int           errors;

  function new();
    paging = 1'b0;
    root   = '0;
    busy   = 1'b0;
    level  = TOP_LEVEL;
    va     = '0;
    acc    = '0;
    errors = 0;
  endfunction

  function logic [8:0] vpn_slice(logic [38:0] v, logic [1:0] lvl);
    return v[12 + 9 * lvl +: 9];
  endfunction

  function logic [1:0] code_for_access(logic [1:0] a);
    return (a == ACC_FETCH) ? FC_INSTR : (a == ACC_LOAD) ? FC_LOAD : FC_STORE;
  endfunction

  function void push(logic [1:0] kind, logic [63:0] addr, logic [1:0] code);
    walk_result_t r;
    r.kind = kind;
    r.addr = addr;
    r.code = code;
    pending_results.push_back(r);
  endfunction

  // Note an accepted input beat; returns 1 when it causes a result
  function bit note_beat(logic mode, logic [63:0] vaddr, logic [1:0] acc_in,
                         logic [63:0] pte);
    logic [43:0] ppn;
    logic [11:0] off;
    logic [63:0] pa;
    ppn = pte[53:10];
    off = va[11:0];
    if (mode == MODE_REQ) begin
      if (busy) return 1'b0;
      if (!paging) begin
        push(KIND_DONE, vaddr, FC_NONE);
        return 1'b1;
      end
      va    = vaddr[38:0];
      acc   = acc_in;
      level = TOP_LEVEL;
      busy  = 1'b1;
      push(KIND_READ, {8'b0, root, vpn_slice(va, level), 3'b000}, FC_NONE);
      return 1'b1;
    end
    if (!busy) return 1'b0;
    // invalid, or write without read
    if (!pte[0] || (!pte[1] && pte[2])) begin
      busy = 1'b0;
      push(KIND_FAULT, '0, code_for_access(acc));
      return 1'b1;
    end
    // leaf: compose page by level
    if (pte[1] || pte[3]) begin
      busy = 1'b0;
      case (level)
        2'd0:    pa = {8'b0, ppn, off};
        2'd1:    pa = {8'b0, pte[53:28], pte[27:19], va[20:12], off};
        default: pa = {8'b0, pte[53:28], va[29:21], va[20:12], off};
      endcase
      push(KIND_DONE, pa, FC_NONE);
      return 1'b1;
    end
    // pointer past the last level
    if (level == 2'd0) begin
      busy = 1'b0;
      push(KIND_FAULT, '0, code_for_access(acc));
      return 1'b1;
    end
    level = level - 2'd1;
    push(KIND_READ, {8'b0, ppn, vpn_slice(va, level), 3'b000}, FC_NONE);
    return 1'b1;
  endfunction

  // Compare one result beat with the oldest expectation
  function void check_result(logic [1:0] kind, logic [63:0] addr, logic [1:0] code);
    walk_result_t e;
    if (pending_results.size() == 0) begin
      $error("unexpected result beat: kind %0d address %h", kind, addr);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (kind !== e.kind) begin
      $error("result_kind: expected %0d, actual %0d", e.kind, kind);
      errors++;
    end
    if (addr !== e.addr) begin
      $error("address: expected %h, actual %h", e.addr, addr);
      errors++;
    end
    if (code !== e.code) begin
      $error("fault_code: expected %0d, actual %0d", e.code, code);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_BEATS = 108;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [1:0] ACC_STORE   = 2'd2;
  localparam logic [1:0] ACC_ODD     = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_mode = MODE_REQ;
  logic [63:0]           in_vaddr = '0;
  logic [1:0]            in_access_kind = '0;
  logic [63:0]           in_pte_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_result_kind;
  logic [63:0]           out_address;
  logic [1:0]            out_fault_code;

  int unsigned    in_idle_pct = 0;
  int unsigned    out_stall_pct = 0;
  int unsigned    cycle_count = 0;
  walk_scoreboard board = new();

  sv39_page_table_walker uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_vaddr       (in_vaddr),
    .in_access_kind (in_access_kind),
    .in_pte_word    (in_pte_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_kind(out_result_kind),
    .out_address    (out_address),
    .out_fault_code (out_fault_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Result monitor, pre-edge values
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_result_kind, out_address, out_fault_code);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Valid non-leaf entry with random PPN and upper bits
  function automatic logic [63:0] pointer_pte();
    logic [63:0] p;
    p = rand64();
    p[3:0] = 4'b0001;
    return p;
  endfunction

  // Present one input beat, hold it until accepted, then log it
  task automatic send_beat(input logic mode, input logic [63:0] vaddr,
                           input logic [1:0] acc, input logic [63:0] pte,
                           output bit made);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_vaddr       <= vaddr;
    in_access_kind <= acc;
    in_pte_word    <= pte;
    do @(posedge clk); while (!in_ready);
    made = board.note_beat(mode, vaddr, acc, pte);
  endtask

  // Stop sending and let every expected beat come back
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write both registers, then a spare index that must be ignored
  task automatic write_regs(input logic paging, input logic [43:0] root);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'(rand64());
    cfg_we    <= 1'b1;
    cfg_index <= REG_PAGING_ON;
    cfg_wdata <= {junk[CFG_DATA_W-1:1], paging};
    @(posedge clk);
    cfg_index <= REG_ROOT_PPN;
    cfg_wdata <= root;
    @(posedge clk);
    cfg_index <= $urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3;
    cfg_wdata <= junk;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.paging = paging;
    board.root   = root;
  endtask

  // One random beat shaped by the walk state: mostly well-formed walks
  task automatic send_random_beat(output bit made);
    logic [63:0] pte;
    logic        r;
    int unsigned pick;
    pte  = rand64();
    pick = $urandom_range(99);
    if (!board.busy) begin
      if (pick < 90) send_beat(MODE_REQ, rand64(), 2'($urandom_range(3)), rand64(), made);
      else send_beat(MODE_PTE, rand64(), 2'($urandom_range(3)), pte, made);
    end else if (pick < 8) begin
      // request while a walk is open
      send_beat(MODE_REQ, rand64(), 2'($urandom_range(3)), pte, made);
    end else begin
      if (pick < 50) begin
        pte[3:0] = 4'b0001;
      end else if (pick < 82) begin
        r = 1'($urandom_range(1));
        pte[0] = 1'b1;
        pte[1] = r;
        if (!r) pte[3:2] = 2'b10;
      end else if (pick < 92) begin
        if ($urandom_range(1)) pte[0] = 1'b0;
        else pte[2:0] = 3'b101;
      end
      send_beat(MODE_PTE, rand64(), 2'($urandom_range(3)), pte, made);
    end
  endtask

  initial begin
    bit          made;
    int unsigned beats;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pass-through with paging off
    write_regs(1'b0, '1);
    send_beat(MODE_REQ, '1, ACC_FETCH, '0, made);
    send_beat(MODE_REQ, '0, ACC_ODD, '1, made);
    send_beat(MODE_PTE, '0, ACC_LOAD, '1, made);
    drain();

    // Directed: walks with the largest root
    write_regs(1'b1, '1);
    send_beat(MODE_REQ, '1, ACC_FETCH, '0, made);
    send_beat(MODE_PTE, '0, ACC_FETCH, '1, made);
    send_beat(MODE_REQ, '0, ACC_LOAD, '0, made);
    send_beat(MODE_PTE, '0, ACC_LOAD, pointer_pte(), made);
    send_beat(MODE_PTE, '0, ACC_LOAD, pointer_pte(), made);
    send_beat(MODE_PTE, '0, ACC_LOAD, pointer_pte(), made);
    send_beat(MODE_REQ, rand64(), ACC_ODD, '0, made);
    send_beat(MODE_PTE, '0, ACC_FETCH, '0, made);
    send_beat(MODE_REQ, rand64(), ACC_STORE, '0, made);
    send_beat(MODE_PTE, '0, ACC_FETCH, 64'h5, made);
    send_beat(MODE_REQ, rand64(), ACC_FETCH, '0, made);
    send_beat(MODE_REQ, rand64(), ACC_LOAD, '0, made);
    send_beat(MODE_PTE, '0, ACC_FETCH, pointer_pte(), made);
    send_beat(MODE_PTE, '0, ACC_FETCH, {60'(rand64() >> 4), 4'b1001}, made);
    send_beat(MODE_REQ, '1, ACC_LOAD, '0, made);
    send_beat(MODE_PTE, '0, ACC_FETCH, pointer_pte(), made);
    send_beat(MODE_PTE, '0, ACC_FETCH, pointer_pte(), made);
    send_beat(MODE_PTE, '0, ACC_FETCH, {60'hfffffffffffffff, 4'b0011}, made);
    drain();

    // Directed: zero root, then registers rewritten mid-walk
    write_regs(1'b1, '0);
    send_beat(MODE_REQ, '1, ACC_STORE, '0, made);
    send_beat(MODE_PTE, '0, ACC_FETCH, {54'b0, 10'h001}, made);
    drain();
    write_regs(1'b0, 44'(rand64()));
    send_beat(MODE_PTE, '0, ACC_FETCH, {60'(rand64() >> 4), 4'b0111}, made);
    drain();

    // Random phases
    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        in_idle_pct   = 18;
        out_stall_pct = 56;
      end else if (p < 6) begin
        in_idle_pct   = 56;
        out_stall_pct = 18;
      end else begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end
      case (p)
        0:       write_regs(1'b1, 44'(rand64()));
        1:       write_regs(1'b1, '1);
        2:       write_regs(1'b0, 44'(rand64()));
        3:       write_regs(1'b1, '0);
        default: write_regs(($urandom_range(3) != 0), 44'(rand64()));
      endcase
      beats = 0;
      while (beats < PHASE_BEATS) begin
        send_random_beat(made);
        if (made) beats++;
        // sender holds off until the result queue is empty
        if (p == 4 && beats == PHASE_BEATS / 2) drain();
      end
      drain();
    end

    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
